// ===== hw/rtl/cqd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cqd_pkg
// Types and codes shared by the circular queue front, back and top level.
// ----------------------------------------------------------------------------
package cqd_pkg;

   localparam int unsigned WORD_W = 32;

   // request opcodes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]               opcode;
      logic signed [WORD_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] data_out;
      logic [1:0]               status;
      logic                     last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_DELETE,
      CMD_DUMP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic signed [WORD_W-1:0] data;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_DUMP
   } back_state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/cqd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cqd_front
// Takes request beats, decodes the opcode and queues commands in a
// two-entry buffer for the back end. Unused opcodes are taken and dropped.
// ----------------------------------------------------------------------------
module cqd_front
   import cqd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         cmd_valid,
   output cmd_type      cmd_data,
   input  wire logic    cmd_pop
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       accept;
   logic       push;
   cmd_type    cmd_new;

   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   // decode
   always_comb begin
      cmd_new.data = req_data.data_in;
      cmd_new.kind = CMD_INSERT;
      push         = 1'b0;
      unique case (req_data.opcode)
         OP_INSERT: begin
            cmd_new.kind = CMD_INSERT;
            push         = accept;
         end
         OP_DELETE: begin
            cmd_new.kind = CMD_DELETE;
            push         = accept;
         end
         OP_DUMP: begin
            cmd_new.kind = CMD_DUMP;
            push         = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, cmd_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ===== hw/rtl/cqd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cqd_back
// Executes queued commands against the ring memory and drives the result
// register. Keeps head, tail and occupancy and walks the ring for dumps.
// ----------------------------------------------------------------------------
module cqd_back
   import cqd_pkg::*;
#(
   parameter int unsigned DEPTH = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_data,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   output logic [$clog2(DEPTH+1)-1:0] occ
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   back_state_type state_ff;
   back_state_type state_in;
   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] head_in;
   logic [PTR_W-1:0] tail_ff;
   logic [PTR_W-1:0] tail_in;
   logic [PTR_W-1:0] ptr_ff;
   logic [PTR_W-1:0] ptr_in;
   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   logic             out_free;
   logic             wr_en;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   logic             load;
   rsp_type          load_data;

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      next_pos = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      ptr_in    = ptr_ff;
      occ_in    = occ_ff;
      cnt_in    = cnt_ff;
      cmd_pop   = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      load      = 1'b0;
      load_data = '{data_out: '0, status: ST_OK, last: 1'b1};
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               unique case (cmd_data.kind)
                  CMD_INSERT: begin
                     load = 1'b1;
                     if (occ_ff == CNT_W'(DEPTH)) begin
                        load_data.status = ST_OVERFLOW;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = next_pos(tail_ff);
                        occ_in  = occ_ff + CNT_W'(1);
                     end
                  end
                  CMD_DELETE: begin
                     if (occ_ff == '0) begin
                        load             = 1'b1;
                        load_data.status = ST_UNDERFLOW;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        head_in  = next_pos(head_ff);
                        occ_in   = occ_ff - CNT_W'(1);
                        state_in = BK_READ;
                     end
                  end
                  CMD_DUMP: begin
                     if (occ_ff == '0) begin
                        load             = 1'b1;
                        load_data.status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        ptr_in   = next_pos(head_ff);
                        cnt_in   = occ_ff;
                        state_in = BK_DUMP;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         BK_READ: begin
            if (out_free) begin
               load               = 1'b1;
               load_data.data_out = rd_data_ff;
               state_in           = BK_IDLE;
            end
         end
         BK_DUMP: begin
            if (out_free) begin
               load               = 1'b1;
               load_data.data_out = rd_data_ff;
               load_data.last     = (cnt_ff == CNT_W'(1));
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = BK_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_ff;
                  ptr_in  = next_pos(ptr_ff);
                  cnt_in  = cnt_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || load;
      rsp_data_in  = load ? load_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         ptr_ff       <= '0;
         occ_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         ptr_ff       <= ptr_in;
         occ_ff       <= occ_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= cmd_data.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign occ       = occ_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/circular_queue_with_dump_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_queue_with_dump_top
// Circular queue of signed 32-bit words with insert, delete and dump.
// ----------------------------------------------------------------------------
// Each request beat carries an opcode: insert (one result, ok or overflow),
// delete (one result with the head word, or underflow) or dump (one result
// per stored word from head to tail, last set on the final one, or a single
// empty result). Opcode 3 is taken and produces nothing. Requests pass
// through a two-entry command buffer, so up to two commands can queue while
// a result waits. Inserts and failing requests finish in the idle state; a
// delete passes through a read state and a dump through a dump state, since
// the ring memory has one read port with a registered output. DEPTH is
// the queue capacity.
// ----------------------------------------------------------------------------
module circular_queue_with_dump_top
   import cqd_pkg::*;
#(
   parameter int unsigned DEPTH = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   logic             cmd_valid;
   cmd_type          cmd_data;
   logic             cmd_pop;
   logic [CNT_W-1:0] occ;

   cqd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   cqd_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .occ       (occ)
   );

   // occupancy stays within capacity
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ <= CNT_W'(DEPTH))
      else $error("occupancy above capacity");

   // error results carry no word and close their request
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |->
         rsp_data.last && (rsp_data.data_out == '0))
      else $error("error result with data or without last");

   // overflow only when full, underflow only when empty
   a_err_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.status == ST_OVERFLOW && occ != CNT_W'(DEPTH)) ||
                    (rsp_data.status == ST_UNDERFLOW && occ != '0)) |-> 1'b0)
      else $error("overflow or underflow does not match occupancy");

endmodule
`default_nettype wire
